@@ rtl/kpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kpu_pkg;

	// Width of factorial values: 12! fits in 29 bits
	localparam int FACT_W = 32;

	typedef struct packed {
		logic [3:0]  set_size;
		logic [18:0] rank;
	} kpu_in_t;

	typedef struct packed {
		logic [3:0] digit;
		logic       last;
		logic       bad_rank;
	} kpu_out_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} kpu_state_t;

	// m! for m = 0..12; codes above 12 never select a digit
	function automatic logic [FACT_W-1:0] fact_of(input logic [3:0] m);
		logic [FACT_W-1:0] f;
		case (m)
			4'd0:    f = 32'd1;
			4'd1:    f = 32'd1;
			4'd2:    f = 32'd2;
			4'd3:    f = 32'd6;
			4'd4:    f = 32'd24;
			4'd5:    f = 32'd120;
			4'd6:    f = 32'd720;
			4'd7:    f = 32'd5040;
			4'd8:    f = 32'd40320;
			4'd9:    f = 32'd362880;
			4'd10:   f = 32'd3628800;
			4'd11:   f = 32'd39916800;
			4'd12:   f = 32'd479001600;
			default: f = '1;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

@@ rtl/kth_permutation_unrank_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An invalid item gives its single error beat in the cycle after accept.
// Each digit is found by repeated steps of the shared compare-subtract unit,
// stepping its pool index up from zero; the beat shows in the cycle after the selecting step.
// A new item is taken only while idle, so not before every digit of the item in hand is selected.
// Results cannot be stalled: each beat is on the result port for one cycle.
// Reset (arst_n low) returns the sequencer to idle and clears the result strobe.

module kth_permutation_unrank_top #(
	parameter int MAX_SET_SIZE = 9
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire kpu_pkg::kpu_in_t item,
	output logic                  busy,
	output logic                  result_strobe,
	output kpu_pkg::kpu_out_t     result
);

	localparam int IDX_W = $clog2(MAX_SET_SIZE);
	localparam int REM_W = $clog2(MAX_SET_SIZE + 1);

	kpu_pkg::kpu_state_t state_q, state_d;

	logic [18:0]                 k_q;
	logic [REM_W-1:0]            rem_q;
	logic [IDX_W-1:0]            idx_q;
	logic [3:0]                  pool_q [MAX_SET_SIZE];
	logic                        strobe_q;
	kpu_pkg::kpu_out_t           result_q;

	logic                        accept;
	logic                        item_ok;
	logic [kpu_pkg::FACT_W-1:0]  f_cur;
	logic [kpu_pkg::FACT_W:0]    diff;
	logic                        k_lt_f;
	logic                        idx_at_end;
	logic                        emit;

	assign accept = start && (state_q == kpu_pkg::ST_IDLE);

	// Range check of the incoming item
	assign item_ok = (item.set_size != 4'd0)
		&& (item.set_size <= 4'(MAX_SET_SIZE))
		&& (item.rank != 19'd0)
		&& ({{(kpu_pkg::FACT_W-19){1'b0}}, item.rank} <= kpu_pkg::fact_of(item.set_size));

	// Shared compare-subtract unit: k against (remaining-1)!
	assign f_cur      = kpu_pkg::fact_of(4'(rem_q - REM_W'(1)));
	assign diff       = {1'b0, {(kpu_pkg::FACT_W-19){1'b0}}, k_q} - {1'b0, f_cur};
	assign k_lt_f     = diff[kpu_pkg::FACT_W];
	assign idx_at_end = (REM_W'(idx_q) == rem_q - REM_W'(1));

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		unique case (state_q)
			kpu_pkg::ST_IDLE: begin
				if (start && item_ok) begin
					state_d = kpu_pkg::ST_RUN;
				end
			end
			kpu_pkg::ST_RUN: begin
				emit = k_lt_f || idx_at_end;
				if (emit && (rem_q == REM_W'(1))) begin
					state_d = kpu_pkg::ST_IDLE;
				end
			end
			default: state_d = kpu_pkg::ST_IDLE;
		endcase
	end

	// Digit datapath: quotient by repeated subtraction, then pool removal
	always_ff @(posedge clk) begin
		if (accept) begin
			k_q   <= item.rank - 19'd1;
			rem_q <= REM_W'(item.set_size);
			idx_q <= '0;
			for (int i = 0; i < MAX_SET_SIZE; i++) begin
				pool_q[i] <= 4'(i + 1);
			end
		end else if (state_q == kpu_pkg::ST_RUN) begin
			if (emit) begin
				rem_q <= rem_q - REM_W'(1);
				idx_q <= '0;
				for (int i = 0; i < MAX_SET_SIZE - 1; i++) begin
					if (i >= int'(idx_q)) begin
						pool_q[i] <= pool_q[i+1];
					end
				end
			end else begin
				k_q   <= diff[18:0];
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (accept && !item_ok) || emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !item_ok) begin
			result_q.digit    <= 4'd0;
			result_q.last     <= 1'b1;
			result_q.bad_rank <= 1'b1;
		end else if (emit) begin
			result_q.digit    <= pool_q[idx_q];
			result_q.last     <= (rem_q == REM_W'(1));
			result_q.bad_rank <= 1'b0;
		end
	end

	assign busy          = (state_q != kpu_pkg::ST_IDLE);
	assign result_strobe = strobe_q;
	assign result        = result_q;

	// Checks
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item_ok) |=> (result_strobe && result.bad_rank && result.last))
		else $error("invalid item did not give an error beat");

	a_digit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.bad_rank) |-> (result.digit != 4'd0))
		else $error("valid beat carries digit zero");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kpu_pkg::ST_RUN) |-> ((REM_W'(idx_q) < rem_q) && (rem_q != '0)))
		else $error("pool index out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (rem_q == REM_W'(1))) |=> (!busy && result_strobe && result.last))
		else $error("last digit did not end the item");

endmodule

`default_nettype wire

@@ tb/kth_permutation_unrank_top_tb.sv @@
`timescale 1ns / 1ps

module kth_permutation_unrank_top_tb;

	localparam int unsigned SET_MAX      = 9;
	localparam int unsigned RANDOM_ITEMS = 197;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned TAIL_CYCLES  = 60;
	localparam int unsigned DRAIN_EVERY  = 50;

	// One row of the directed table: when typed, digits are read as hex nibbles,
	// first digit in the most significant nibble of the n used.
	typedef struct packed {
		logic [3:0]  n;
		logic [18:0] k;
		logic        typed;
		logic        bad;
		logic [35:0] digs;
	} dir_row_t;

	localparam int unsigned DIR_COUNT = 23;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{4'd1,  19'd1,       1'b1, 1'b0, 36'h1},         // first item after reset
		'{4'd1,  19'd2,       1'b1, 1'b1, 36'h0},
		'{4'd0,  19'd1,       1'b1, 1'b1, 36'h0},         // empty set
		'{4'd9,  19'd0,       1'b1, 1'b1, 36'h0},         // rank zero
		'{4'd9,  19'd1,       1'b1, 1'b0, 36'h123456789},
		'{4'd9,  19'd362880,  1'b1, 1'b0, 36'h987654321},
		'{4'd9,  19'd362881,  1'b1, 1'b1, 36'h0},         // one past 9!
		'{4'd9,  19'h7FFFF,   1'b1, 1'b1, 36'h0},
		'{4'd15, 19'd1,       1'b1, 1'b1, 36'h0},         // set size too large
		'{4'd10, 19'd1,       1'b1, 1'b1, 36'h0},
		'{4'd2,  19'd1,       1'b1, 1'b0, 36'h12},
		'{4'd2,  19'd2,       1'b1, 1'b0, 36'h21},
		'{4'd3,  19'd4,       1'b1, 1'b0, 36'h231},
		'{4'd3,  19'd6,       1'b1, 1'b0, 36'h321},
		'{4'd3,  19'd7,       1'b1, 1'b1, 36'h0},
		'{4'd8,  19'd40320,   1'b1, 1'b0, 36'h87654321},
		'{4'd8,  19'd40321,   1'b1, 1'b1, 36'h0},
		'{4'd7,  19'd5040,    1'b1, 1'b0, 36'h7654321},
		'{4'd4,  19'd0,       1'b1, 1'b1, 36'h0},
		'{4'd5,  19'd17,      1'b0, 1'b0, 36'h0},
		'{4'd6,  19'd500,     1'b0, 1'b0, 36'h0},
		'{4'd9,  19'd200000,  1'b0, 1'b0, 36'h0},
		'{4'd12, 19'h7FFFF,   1'b1, 1'b1, 36'h0}
	};

	logic              clk;
	logic              arst_n;
	logic              start;
	kpu_pkg::kpu_in_t  item;
	logic              busy;
	logic              result_strobe;
	kpu_pkg::kpu_out_t result;

	kpu_pkg::kpu_out_t digits_due[$];
	int unsigned       mismatches;
	int unsigned       idle_cycles;
	int unsigned       burst_left;

	kth_permutation_unrank_top #(
		.MAX_SET_SIZE(SET_MAX)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_strobe(result_strobe),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned perm_count(int unsigned m);
		int unsigned f;
		f = 1;
		for (int unsigned i = 2; i <= m; i++)
			f *= i;
		return f;
	endfunction

	// Add one expected beat at the tail of the queue
	function automatic void append_beat(kpu_pkg::kpu_out_t b);
		digits_due.insert(digits_due.size(), b);
	endfunction

	// Unrank k into the digits of the k-th permutation of 1..n and queue the beats
	function automatic void push_unranked_digits(logic [3:0] n, logic [18:0] k);
		int unsigned       pool [SET_MAX];
		int unsigned       left;
		int unsigned       rest;
		int unsigned       f;
		int unsigned       idx;
		kpu_pkg::kpu_out_t beat;
		if (n == 4'd0 || n > SET_MAX || k == '0 || k > perm_count(n)) begin
			beat.digit    = 4'd0;
			beat.last     = 1'b1;
			beat.bad_rank = 1'b1;
			append_beat(beat);
		end else begin
			for (int unsigned p = 0; p < SET_MAX; p++)
				pool[p] = p + 1;
			left = n;
			rest = k - 1;
			for (int unsigned p = 0; p < n; p++) begin
				f    = perm_count(left - 1);
				idx  = rest / f;
				rest = rest % f;
				if (idx >= left)
					idx = left - 1;
				beat.digit    = pool[idx][3:0];
				beat.last     = (p + 1 == n);
				beat.bad_rank = 1'b0;
				append_beat(beat);
				for (int unsigned j = idx; j + 1 < left; j++)
					pool[j] = pool[j + 1];
				left--;
			end
		end
	endfunction

	// Present one item and hold it until the edge that takes it
	task automatic send_item(kpu_pkg::kpu_in_t x);
		start <= 1'b1;
		item  <= x;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Burst pacing: idle a random gap once the current burst runs out
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
			                                         : $urandom_range(0, 6);
		end
	endtask

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin : check_beats
		kpu_pkg::kpu_out_t want;
		if (arst_n && result_strobe) begin
			if (digits_due.size() == 0) begin
				$display("%0t: unexpected beat digit=%0d last=%0b bad=%0b", $time,
				         result.digit, result.last, result.bad_rank);
				mismatches++;
			end else begin
				want = digits_due.pop_front();
				if (result.digit !== want.digit || result.last !== want.last ||
				    result.bad_rank !== want.bad_rank) begin
					$display("%0t: expected digit=%0d last=%0b bad=%0b,", $time,
					         want.digit, want.last, want.bad_rank,
					         " got digit=%0d last=%0b bad=%0b",
					         result.digit, result.last, result.bad_rank);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: no item taken and no beat seen for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("kth_permutation_unrank_top_tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		kpu_pkg::kpu_in_t  x;
		dir_row_t          row;
		kpu_pkg::kpu_out_t beat;
		int unsigned       n;
		int unsigned       k;
		burst_left  = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int unsigned i = 0; i < DIR_COUNT; i++) begin
			row        = DIR_ROWS[i];
			x.set_size = row.n;
			x.rank     = row.k;
			send_item(x);
			if (!row.typed) begin
				push_unranked_digits(x.set_size, x.rank);
			end else if (row.bad) begin
				beat.digit    = 4'd0;
				beat.last     = 1'b1;
				beat.bad_rank = 1'b1;
				append_beat(beat);
			end else begin
				for (int unsigned j = 0; j < row.n; j++) begin
					beat.digit    = row.digs[4 * (row.n - 1 - j) +: 4];
					beat.last     = (j + 1 == row.n);
					beat.bad_rank = 1'b0;
					append_beat(beat);
				end
			end
			pace_sender();
		end

		// Random part: mostly valid ranks, some boundaries, some raw noise
		for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
			n = $urandom_range(1, SET_MAX);
			case ($urandom_range(0, 9))
				8: begin
					case ($urandom_range(0, 2))
						0:       k = perm_count(n);
						1:       k = perm_count(n) + 1;
						default: k = 0;
					endcase
				end
				9: begin
					n = $urandom_range(0, 15);
					k = $urandom_range(0, 19'h7FFFF);
				end
				default: k = $urandom_range(1, perm_count(n));
			endcase
			x.set_size = n[3:0];
			x.rank     = k[18:0];
			send_item(x);
			push_unranked_digits(x.set_size, x.rank);
			if (i % DRAIN_EVERY == DRAIN_EVERY / 2) begin
				// hold off until the block has emitted everything owed
				start <= 1'b0;
				while (digits_due.size() != 0)
					@(posedge clk);
			end else begin
				pace_sender();
			end
		end

		start <= 1'b0;
		while (digits_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && digits_due.size() == 0)
			$display("kth_permutation_unrank_top_tb OK");
		else
			$display("kth_permutation_unrank_top_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/kpu_pkg.sv
rtl/kth_permutation_unrank_top.sv
tb/kth_permutation_unrank_top_tb.sv
